[hw/rtl/rrg_pkg.sv]
// shared types and constants for the ranged random generator
// used by rrg_mul, rrg_ctrl and ranged_random_generator_core; no dependencies

package rrg_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned HalfW    = WordW / 2;
  localparam int unsigned ProdW    = 2 * WordW;
  localparam int unsigned MulSteps = 4;
  localparam int unsigned StepW    = $clog2(MulSteps + 1);

  localparam logic [WordW-1:0] MixGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WordW-1:0] MixMulA  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MixMulB  = 64'h94d0_49bb_1331_11eb;
  localparam logic [WordW-1:0] AllOnes  = '1;

  localparam int unsigned MixShA  = 30;
  localparam int unsigned MixShB  = 27;
  localparam int unsigned MixShC  = 31;
  localparam int unsigned XoroRotA = 24;
  localparam int unsigned XoroShB  = 16;
  localparam int unsigned XoroRotC = 37;
  localparam int unsigned XoroRotW = 7;

  typedef enum logic [1:0] {
    CFG_GEN_SEL     = 2'd0,
    CFG_SEED_FIRST  = 2'd1,
    CFG_SEED_SECOND = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XORO_A,
    S_XORO_B,
    S_MIX_A,
    S_MIX_AW,
    S_MIX_BW,
    S_RANGE,
    S_RNG_W,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_MIX_A,
    MUL_MIX_B,
    MUL_RANGE
  } mul_op_e;

  typedef enum logic [1:0] {
    RES_LOW,
    RES_RAW,
    RES_SCALED
  } res_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     ld_range;
    logic     xoro_step;
    logic     xoro_mul9;
    logic     mix_step;
    logic     mul_start;
    mul_op_e  mul_op;
    logic     ld_raw_mix;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic gen_sel;
    logic mul_done;
    logic range_empty;
    logic range_full;
    logic out_free;
  } stat_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned k);
    rotl = (v << k) | (v >> (WordW - k));
  endfunction

endpackage

[hw/rtl/rrg_mul.sv]
// 64 x 64 multiplier built from one 32 x 32 multiplier over four partial products
// full 128-bit product; depends on rrg_pkg

module rrg_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rrg_pkg::WordW-1:0]   a_i,
  input  logic [rrg_pkg::WordW-1:0]   b_i,
  output logic                        done_o,
  output logic [rrg_pkg::ProdW-1:0]   prod_o
);

  logic [rrg_pkg::WordW-1:0] a_q, b_q;
  logic [rrg_pkg::WordW-1:0] pp_q, pp_d;
  logic [1:0]                psel_q;
  logic [rrg_pkg::StepW-1:0] step_q;
  logic                      active_q, done_q;
  logic [rrg_pkg::ProdW-1:0] acc_q, pp_ext;
  logic [rrg_pkg::HalfW-1:0] op_a, op_b;
  logic                      issue, accum, last;

  assign last  = (step_q == rrg_pkg::StepW'(rrg_pkg::MulSteps));
  assign issue = active_q && !last;
  assign accum = active_q && (step_q != '0);

  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        op_a = a_q[rrg_pkg::HalfW-1:0];
        op_b = b_q[rrg_pkg::HalfW-1:0];
      end
      2'd1: begin
        op_a = a_q[rrg_pkg::HalfW-1:0];
        op_b = b_q[rrg_pkg::WordW-1:rrg_pkg::HalfW];
      end
      2'd2: begin
        op_a = a_q[rrg_pkg::WordW-1:rrg_pkg::HalfW];
        op_b = b_q[rrg_pkg::HalfW-1:0];
      end
      default: begin
        op_a = a_q[rrg_pkg::WordW-1:rrg_pkg::HalfW];
        op_b = b_q[rrg_pkg::WordW-1:rrg_pkg::HalfW];
      end
    endcase
    pp_d = {{rrg_pkg::HalfW{1'b0}}, op_a} * {{rrg_pkg::HalfW{1'b0}}, op_b};
  end

  // place the previous partial product at its weight
  always_comb begin
    case (psel_q)
      2'd0:    pp_ext = {{rrg_pkg::WordW{1'b0}}, pp_q};
      2'd1,
      2'd2:    pp_ext = {{rrg_pkg::HalfW{1'b0}}, pp_q, {rrg_pkg::HalfW{1'b0}}};
      default: pp_ext = {pp_q, {rrg_pkg::WordW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= active_q && last;
      if (start_i) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (active_q) begin
        if (last) active_q <= 1'b0;
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (issue) begin
        pp_q   <= pp_d;
        psel_q <= step_q[1:0];
      end
      if (accum) acc_q <= acc_q + pp_ext;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hw/rtl/rrg_ctrl.sv]
// sequencer for the ranged random generator: request intake, generator steps,
// multiplier scheduling and result hand-off; depends on rrg_pkg

module rrg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrg_pkg::stat_t stat_i,
  output rrg_pkg::ctrl_t ctrl_o
);

  rrg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rrg_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrg_pkg::S_IDLE: begin
        if (stat_i.in_valid) state_d = stat_i.gen_sel ? rrg_pkg::S_MIX_A : rrg_pkg::S_XORO_A;
      end
      rrg_pkg::S_XORO_A: state_d = rrg_pkg::S_XORO_B;
      rrg_pkg::S_XORO_B: state_d = rrg_pkg::S_RANGE;
      rrg_pkg::S_MIX_A:  state_d = rrg_pkg::S_MIX_AW;
      rrg_pkg::S_MIX_AW: begin
        if (stat_i.mul_done) state_d = rrg_pkg::S_MIX_BW;
      end
      rrg_pkg::S_MIX_BW: begin
        if (stat_i.mul_done) state_d = rrg_pkg::S_RANGE;
      end
      rrg_pkg::S_RANGE: begin
        if (stat_i.range_empty || stat_i.range_full) state_d = rrg_pkg::S_DONE;
        else                                          state_d = rrg_pkg::S_RNG_W;
      end
      rrg_pkg::S_RNG_W: begin
        if (stat_i.mul_done) state_d = rrg_pkg::S_DONE;
      end
      rrg_pkg::S_DONE: begin
        if (stat_i.out_free) state_d = rrg_pkg::S_IDLE;
      end
      default: state_d = rrg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_op  = rrg_pkg::MUL_RANGE;
    ctrl_o.res_sel = rrg_pkg::RES_LOW;
    case (state_q)
      rrg_pkg::S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.ld_range = stat_i.in_valid;
      end
      rrg_pkg::S_XORO_A: ctrl_o.xoro_step = 1'b1;
      rrg_pkg::S_XORO_B: ctrl_o.xoro_mul9 = 1'b1;
      rrg_pkg::S_MIX_A: begin
        ctrl_o.mix_step  = 1'b1;
        ctrl_o.mul_start = 1'b1;
        ctrl_o.mul_op    = rrg_pkg::MUL_MIX_A;
      end
      rrg_pkg::S_MIX_AW: begin
        ctrl_o.mul_start = stat_i.mul_done;
        ctrl_o.mul_op    = rrg_pkg::MUL_MIX_B;
      end
      rrg_pkg::S_MIX_BW: ctrl_o.ld_raw_mix = stat_i.mul_done;
      rrg_pkg::S_RANGE: begin
        if (stat_i.range_empty) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_sel  = rrg_pkg::RES_LOW;
        end else if (stat_i.range_full) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_sel  = rrg_pkg::RES_RAW;
        end else begin
          ctrl_o.mul_start = 1'b1;
          ctrl_o.mul_op    = rrg_pkg::MUL_RANGE;
        end
      end
      rrg_pkg::S_RNG_W: begin
        ctrl_o.res_load = stat_i.mul_done;
        ctrl_o.res_sel  = rrg_pkg::RES_SCALED;
      end
      rrg_pkg::S_DONE: ctrl_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[hw/rtl/ranged_random_generator_core.sv]
// ranged random generator: xoroshiro128** or splitmix64 word scaled into [low, high]
// an empty or full range skips the range multiply; each multiply runs on the shared
// 32 x 32 multiplier in rrg_mul; one request at a time, the next taken only once the
// result has moved to the output register
// reset: generator select 0, splitmix state 0, xoroshiro words 0 and all ones
// depends on rrg_pkg, rrg_mul, rrg_ctrl

module ranged_random_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [rrg_pkg::WordW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [rrg_pkg::WordW-1:0] range_low_i,
  input  logic [rrg_pkg::WordW-1:0] range_high_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rrg_pkg::WordW-1:0] random_value_o
);

  rrg_pkg::ctrl_t ctrl;
  rrg_pkg::stat_t stat;

  logic                      gen_sel_q;
  logic [rrg_pkg::WordW-1:0] mix_q, xoro0_q, xoro1_q;
  logic [rrg_pkg::WordW-1:0] lo_q, hi_q, raw_q, res_q, out_q;
  logic                      out_vld_q;

  logic [rrg_pkg::WordW-1:0] mix_next, xoro_s1, xoro0_next, xoro1_next, xoro_word;
  logic [rrg_pkg::WordW-1:0] mul_a, mul_b, prod_lo, span;
  logic [rrg_pkg::ProdW-1:0] prod;
  logic                      mul_done;

  assign mix_next   = mix_q + rrg_pkg::MixGamma;
  assign xoro_s1    = xoro1_q ^ xoro0_q;
  assign xoro0_next = rrg_pkg::rotl(xoro0_q, rrg_pkg::XoroRotA) ^ xoro_s1
                      ^ (xoro_s1 << rrg_pkg::XoroShB);
  assign xoro1_next = rrg_pkg::rotl(xoro_s1, rrg_pkg::XoroRotC);
  // s0 * 5 then rotate; the * 9 follows in the next cycle
  assign xoro_word  = rrg_pkg::rotl(xoro0_q + (xoro0_q << 2), rrg_pkg::XoroRotW);
  assign prod_lo    = prod[rrg_pkg::WordW-1:0];
  assign span       = hi_q - lo_q + 64'd1;

  always_comb begin
    case (ctrl.mul_op)
      rrg_pkg::MUL_MIX_A: begin
        mul_a = mix_next ^ (mix_next >> rrg_pkg::MixShA);
        mul_b = rrg_pkg::MixMulA;
      end
      rrg_pkg::MUL_MIX_B: begin
        mul_a = prod_lo ^ (prod_lo >> rrg_pkg::MixShB);
        mul_b = rrg_pkg::MixMulB;
      end
      default: begin
        mul_a = raw_q;
        mul_b = span;
      end
    endcase
  end

  rrg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign stat.in_valid    = in_valid_i;
  assign stat.gen_sel     = gen_sel_q;
  assign stat.mul_done    = mul_done;
  assign stat.range_empty = (hi_q <= lo_q);
  assign stat.range_full  = (lo_q == '0) && (hi_q == rrg_pkg::AllOnes);
  assign stat.out_free    = !out_vld_q || !out_stall_i;

  rrg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // generator state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_sel_q <= 1'b0;
      mix_q     <= '0;
      xoro0_q   <= '0;
      xoro1_q   <= rrg_pkg::AllOnes;
    end else begin
      if (ctrl.mix_step) mix_q <= mix_next;
      if (ctrl.xoro_step) begin
        xoro0_q <= xoro0_next;
        xoro1_q <= xoro1_next;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rrg_pkg::CFG_GEN_SEL: gen_sel_q <= cfg_data_i[0];
          rrg_pkg::CFG_SEED_FIRST: begin
            mix_q   <= cfg_data_i;
            xoro0_q <= cfg_data_i;
          end
          rrg_pkg::CFG_SEED_SECOND: xoro1_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // request operands and working words
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_range) begin
      lo_q <= range_low_i;
      hi_q <= range_high_i;
    end
    if (ctrl.xoro_step)  raw_q <= xoro_word;
    if (ctrl.xoro_mul9)  raw_q <= raw_q + (raw_q << 3);
    if (ctrl.ld_raw_mix) raw_q <= prod_lo ^ (prod_lo >> rrg_pkg::MixShC);
    if (ctrl.res_load) begin
      case (ctrl.res_sel)
        rrg_pkg::RES_LOW:    res_q <= lo_q;
        rrg_pkg::RES_RAW:    res_q <= raw_q;
        default:             res_q <= lo_q + prod[rrg_pkg::ProdW-1:rrg_pkg::WordW];
      endcase
    end
    if (ctrl.out_load) out_q <= res_q;
  end

  // output register holds the result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign in_stall_o     = !ctrl.in_ready;
  assign out_valid_o    = out_vld_q;
  assign random_value_o = out_q;

endmodule
